// ----- rtl/core/tfd_pkg.sv -----
// Shared types, widths and constants of the timestamp frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package tfd_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 13;
  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [7:0] HDR_BYTE0 = 8'd1;
  localparam logic [7:0] HDR_BYTE1 = 8'd11;

  // Field widths
  localparam int CNT_W  = 24;
  localparam int SEC_W  = 32;
  localparam int FRAC_W = 43;
  localparam int STEP_W = 2 * CNT_W + 1;
  localparam int REM_W  = 27;
  localparam int QUO_W  = 24;
  localparam int SUM_W  = 45;
  localparam int TDATA_W = 88;

  // Radix-4 division of the step count by 10^8
  localparam logic [REM_W+1:0] DIV_X1 = 29'd100000000;
  localparam logic [REM_W+1:0] DIV_X2 = 29'd200000000;
  localparam logic [REM_W+1:0] DIV_X3 = 29'd300000000;
  localparam logic [3:0] DIV_DONE = 4'd12;

  // One second in ticks of 10 ns / 65536, and the fine counter zero point
  localparam logic [FRAC_W-1:0] TICKS_PER_SEC = 43'd6553600000000;
  localparam logic [SUM_W-1:0]  TICKS_X1 = SUM_W'(TICKS_PER_SEC);
  localparam logic [SUM_W-1:0]  TICKS_X2 = SUM_W'(TICKS_PER_SEC) << 1;
  localparam logic [SUM_W-1:0]  FINE_ZERO = 45'd4194303;

  // Configuration register indexes
  localparam logic [1:0] REG_STEP     = 2'd0;
  localparam logic [1:0] REG_OFF_SEC  = 2'd1;
  localparam logic [1:0] REG_OFF_FRAC = 2'd2;

  // Frame queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CSUM = 2'd1,
    ST_HDR  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]       number;
    logic [CNT_W-1:0] coarse;
    logic [CNT_W-1:0] middle;
    logic [CNT_W-1:0] fine;
    status_t          status;
  } frame_t;

endpackage
`default_nettype wire

// ----- rtl/core/tfd_front.sv -----
// Byte assembler: collects frame bytes, checks header and checksum.
`timescale 1ns / 1ps
`default_nettype none
module tfd_front import tfd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_start,
  input  wire logic       q_full,
  output logic            in_ready,
  output logic            push,
  output frame_t          frame
);

  logic [POS_W-1:0] pos_r, pos_nxt, pos;
  logic [7:0]       xor_r, xor_nxt, xor_base;
  logic             hdr_r, hdr_nxt, hdr_base;
  logic [7:0]       num_r, num_nxt;
  logic [CNT_W-1:0] coarse_r, coarse_nxt;
  logic [CNT_W-1:0] medium_r, medium_nxt;
  logic [CNT_W-1:0] fine_r, fine_nxt;
  logic             accept, active;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  // A byte outside a frame is dropped unless it opens a new one.
  assign active   = accept && (in_start || (pos_r != '0));
  assign pos      = in_start ? '0 : pos_r;
  assign xor_base = in_start ? 8'd0 : xor_r;
  assign hdr_base = in_start ? 1'b1 : hdr_r;

  always_comb begin
    pos_nxt    = pos_r;
    xor_nxt    = xor_r;
    hdr_nxt    = hdr_r;
    num_nxt    = num_r;
    coarse_nxt = coarse_r;
    medium_nxt = medium_r;
    fine_nxt   = fine_r;
    push       = 1'b0;
    if (active) begin
      if (pos != LAST_POS) begin
        xor_nxt = xor_base ^ in_byte;
        hdr_nxt = hdr_base;
        pos_nxt = pos + 1'b1;
        case (pos)
          4'd0:    hdr_nxt = (in_byte == HDR_BYTE0);
          4'd1:    hdr_nxt = hdr_base && (in_byte == HDR_BYTE1);
          4'd2:    num_nxt = in_byte;
          4'd3:    coarse_nxt[7:0]   = in_byte;
          4'd4:    coarse_nxt[15:8]  = in_byte;
          4'd5:    coarse_nxt[23:16] = in_byte;
          4'd6:    medium_nxt[7:0]   = in_byte;
          4'd7:    medium_nxt[15:8]  = in_byte;
          4'd8:    medium_nxt[23:16] = in_byte;
          4'd9:    fine_nxt[7:0]     = in_byte;
          4'd10:   fine_nxt[15:8]    = in_byte;
          4'd11:   fine_nxt[23:16]   = in_byte;
          default: ;
        endcase
      end else begin
        pos_nxt = '0;
        push    = 1'b1;
      end
    end
  end

  always_comb begin
    frame.number = num_r;
    frame.coarse = coarse_r;
    frame.middle = medium_r;
    frame.fine   = fine_r;
    if (xor_r != in_byte) begin
      frame.status = ST_CSUM;
    end else if (!hdr_r) begin
      frame.status = ST_HDR;
    end else begin
      frame.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      xor_r <= 8'd0;
      hdr_r <= 1'b1;
    end else begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
      hdr_r <= hdr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r    <= num_nxt;
    coarse_r <= coarse_nxt;
    medium_r <= medium_nxt;
    fine_r   <= fine_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/tfd_queue.sv -----
// Short frame queue between the assembler and the time calculation.
`timescale 1ns / 1ps
`default_nettype none
module tfd_queue import tfd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire frame_t wr_frame,
  input  wire logic   pop,
  output logic        full,
  output logic        valid,
  output frame_t      rd_frame
);

  frame_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wp_r, rp_r;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign valid    = (cnt_r != '0);
  assign rd_frame = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_frame;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tfd_back.sv -----
// Time calculation: radix-4 divider, fraction sum, second carry and output register.
`timescale 1ns / 1ps
`default_nettype none
module tfd_back import tfd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire frame_t            q_frame,
  output logic                   q_pop,
  input  wire logic              step_20ns,
  input  wire logic [SEC_W-1:0]  off_sec,
  input  wire logic [FRAC_W-1:0] off_frac,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_number,
  output logic [SEC_W-1:0]       out_sec,
  output logic [FRAC_W-1:0]      out_frac,
  output status_t                out_status
);

  // Divider stage
  logic             busy_r;
  logic [3:0]       cnt_r;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] sh_r;
  logic [QUO_W-1:0] quo_r;
  logic [1:0]       digit;
  logic [7:0]       d_num_r;
  logic [CNT_W-1:0] d_fine_r;
  status_t          d_status_r;
  logic [REM_W+1:0] trial;
  logic [STEP_W-1:0] steps;

  // Sum stage
  logic             a_valid_r;
  logic [SUM_W-1:0] a_sum_r;
  logic [SEC_W-1:0] a_sec_r;
  logic [7:0]       a_num_r;
  status_t          a_status_r;

  // Output register
  logic              o_valid_r;
  logic [7:0]        o_num_r;
  logic [SEC_W-1:0]  o_sec_r, o_sec_nxt;
  logic [FRAC_W-1:0] o_frac_r, o_frac_nxt;
  status_t           o_status_r;

  logic out_free, a_free, a_move, d_done, d_move;
  logic neg, ge1, ge2;
  logic [SUM_W-1:0] frac_fix;
  logic [SEC_W-1:0] sec_carry;

  assign out_free = !o_valid_r || out_ready;
  assign a_move   = a_valid_r && out_free;
  assign a_free   = !a_valid_r || out_free;
  assign d_done   = busy_r && (cnt_r == DIV_DONE);
  assign d_move   = d_done && a_free;
  assign q_pop    = q_valid && (!busy_r || d_move);

  assign steps = step_20ns ? {q_frame.coarse, q_frame.middle, 1'b0}
                           : {1'b0, q_frame.coarse, q_frame.middle};

  // One quotient digit per cycle: three parallel compares against 1, 2 and 3 times 10^8.
  assign trial = {rem_r, sh_r[CNT_W-1 -: 2]};
  always_comb begin
    if (trial >= DIV_X3) begin
      digit   = 2'd3;
      rem_nxt = REM_W'(trial - DIV_X3);
    end else if (trial >= DIV_X2) begin
      digit   = 2'd2;
      rem_nxt = REM_W'(trial - DIV_X2);
    end else if (trial >= DIV_X1) begin
      digit   = 2'd1;
      rem_nxt = REM_W'(trial - DIV_X1);
    end else begin
      digit   = 2'd0;
      rem_nxt = REM_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd0;
    end else if (d_move) begin
      busy_r <= 1'b0;
    end else if (busy_r && !d_done) begin
      cnt_r <= cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem_r      <= REM_W'(steps[STEP_W-1:CNT_W]);
      sh_r       <= steps[CNT_W-1:0];
      quo_r      <= '0;
      d_num_r    <= q_frame.number;
      d_fine_r   <= q_frame.fine;
      d_status_r <= q_frame.status;
    end else if (busy_r && !d_done) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[CNT_W-3:0], 2'b00};
      quo_r <= {quo_r[QUO_W-3:0], digit};
    end
  end

  // Fraction before the carry into seconds; may be negative or up to about 2.34 seconds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (d_move) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (d_move) begin
      a_sum_r    <= {2'b00, rem_r, 16'h0000} + SUM_W'(d_fine_r) - FINE_ZERO
                    + SUM_W'(off_frac);
      a_sec_r    <= SEC_W'(quo_r) + off_sec;
      a_num_r    <= d_num_r;
      a_status_r <= d_status_r;
    end
  end

  // Floor the fraction into [0, one second) and carry the whole seconds; a failed frame gets zero time.
  assign neg = a_sum_r[SUM_W-1];
  assign ge2 = !neg && (a_sum_r >= TICKS_X2);
  assign ge1 = !neg && (a_sum_r >= TICKS_X1);

  always_comb begin
    if (neg) begin
      frac_fix  = a_sum_r + TICKS_X1;
      sec_carry = '1;
    end else if (ge2) begin
      frac_fix  = a_sum_r - TICKS_X2;
      sec_carry = SEC_W'(2);
    end else if (ge1) begin
      frac_fix  = a_sum_r - TICKS_X1;
      sec_carry = SEC_W'(1);
    end else begin
      frac_fix  = a_sum_r;
      sec_carry = '0;
    end
    if (a_status_r == ST_OK) begin
      o_sec_nxt  = a_sec_r + sec_carry;
      o_frac_nxt = frac_fix[FRAC_W-1:0];
    end else begin
      o_sec_nxt  = '0;
      o_frac_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (a_move) begin
      o_valid_r <= 1'b1;
    end else if (out_ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      o_num_r    <= a_num_r;
      o_sec_r    <= o_sec_nxt;
      o_frac_r   <= o_frac_nxt;
      o_status_r <= a_status_r;
    end
  end

  assign out_valid  = o_valid_r;
  assign out_number = o_num_r;
  assign out_sec    = o_sec_r;
  assign out_frac   = o_frac_r;
  assign out_status = o_status_r;

endmodule
`default_nettype wire

// ----- rtl/core/timestamp_frame_decoder_top.sv -----
// Top level of the timestamp frame decoder: register file and stream ports.
// A result passes the frame queue, the divider, the sum and the output registers.
// Throughput: one byte beat per cycle while the frame queue is not full; the
// radix-4 divider handles one frame at a time: a load, then 12 digit steps.
// A two-entry frame queue lets the byte side keep running while results wait.
// Reset (rst_n low, synchronous) clears the registers to 0, empties the queue
// and the pipeline, and leaves the assembler waiting for a frame start.
`timescale 1ns / 1ps
`default_nettype none
module timestamp_frame_decoder_top import tfd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input stream of frame bytes
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]         in_tuser,   // [0] frame_start
  // Result stream
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // [7:0] event_number, [39:8] whole_seconds,
                                              // [82:40] fraction_ticks, [87:83] zero
  output logic [1:0]              out_tuser,  // [1:0] status
  // Register port
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [4:0]         cfg_paddr,
  input  wire logic [63:0]        cfg_pwdata,
  output logic [63:0]             cfg_prdata,
  output logic                    cfg_pready
);

  // Registers sit at eight-byte spacing, so the index is the upper address bits.
  logic              step_r;
  logic [SEC_W-1:0]  off_sec_r;
  logic [FRAC_W-1:0] off_frac_r;
  logic [1:0]        reg_idx;
  logic              reg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:3];
  assign reg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= 1'b0;
      off_sec_r  <= '0;
      off_frac_r <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_STEP:     step_r     <= cfg_pwdata[0];
        REG_OFF_SEC:  off_sec_r  <= cfg_pwdata[SEC_W-1:0];
        REG_OFF_FRAC: off_frac_r <= cfg_pwdata[FRAC_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STEP:     cfg_prdata = 64'(step_r);
      REG_OFF_SEC:  cfg_prdata = 64'(off_sec_r);
      REG_OFF_FRAC: cfg_prdata = 64'(off_frac_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // The assembler hands each completed frame, already classified, to the queue.
  frame_t front_frame, queue_frame;
  logic   push, pop, q_full, q_valid;

  tfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_start (in_tuser[0]),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .frame    (front_frame)
  );

  tfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_frame (front_frame),
    .pop      (pop),
    .full     (q_full),
    .valid    (q_valid),
    .rd_frame (queue_frame)
  );

  // The back end divides the step count into seconds, then floors the fraction.
  logic [7:0]        res_number;
  logic [SEC_W-1:0]  res_sec;
  logic [FRAC_W-1:0] res_frac;
  status_t           res_status;

  tfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_frame    (queue_frame),
    .q_pop      (pop),
    .step_20ns  (step_r),
    .off_sec    (off_sec_r),
    .off_frac   (off_frac_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_number (res_number),
    .out_sec    (res_sec),
    .out_frac   (res_frac),
    .out_status (res_status)
  );

  assign out_tdata = {5'b00000, res_frac, res_sec, res_number};
  assign out_tuser = res_status;

endmodule
`default_nettype wire

// ----- rtl/core/tfd_checker.sv -----
// Port-level assertions for the timestamp frame decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tfd_checker import tfd_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata,
  input wire logic [1:0]         out_tuser
);

  // A result waiting for the sink keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A failed frame carries no time.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[82:8] == '0))
    else $error("failed frame carries a time");

  // The fraction is always floored below one second.
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[82:40] < TICKS_PER_SEC))
    else $error("fraction not below one second");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind timestamp_frame_decoder_top tfd_checker u_tfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the timestamp frame decoder top level.
`timescale 1ns / 1ps
module tb;
  import tfd_pkg::*;

  // The bench keeps its own arithmetic constants rather than the package ones,
  // so the expected time is worked out independently of the design.
  localparam longint STEPS_PER_SECOND = 64'sd100000000;
  localparam longint SECOND_TICKS     = 64'sd6553600000000;
  localparam longint FINE_BIAS        = 64'sd4194303;
  localparam int     PHASE_ITEMS      = 190;
  localparam int     SETTLE_CYCLES    = 40;
  localparam int     HOLD_CYCLES      = 300;

  // What comes in front of a frame: nothing, stray bytes sent while the
  // assembler is idle, or an abandoned partial frame that the new start cuts off.
  typedef enum logic [1:0] {
    LEAD_NONE,
    LEAD_STRAY,
    LEAD_PARTIAL
  } lead_t;

  // One decoded timestamp as it should leave the block.
  typedef struct packed {
    logic [7:0]  number;
    logic [31:0] secs;
    logic [42:0] frac;
    status_t     status;
  } stamp_t;

  // One row of the directed table. Where typed is set, want holds the result
  // as read straight off the frame; otherwise the predictor supplies it.
  typedef struct packed {
    logic [7:0]  hdr0;
    logic [7:0]  hdr1;
    logic [7:0]  number;
    logic [23:0] coarse;
    logic [23:0] middle;
    logic [23:0] fine;
    logic        csum_bad;
    lead_t       lead;
    logic        typed;
    stamp_t      want;
  } frame_row_t;

  // Clock and reset. Reset is held low at the start and then released for good.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Everything the bench drives starts at a known value.
  logic               in_tvalid = 1'b0;
  logic [7:0]         in_tdata = 8'h00;
  logic [0:0]         in_tuser = 1'b0;
  logic               out_tready = 1'b0;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [4:0]         cfg_paddr = 5'd0;
  logic [63:0]        cfg_pwdata = 64'd0;
  wire                in_tready;
  wire                out_tvalid;
  wire [TDATA_W-1:0]  out_tdata;
  wire [1:0]          out_tuser;
  wire [63:0]         cfg_prdata;
  wire                cfg_pready;

  timestamp_frame_decoder_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Timestamps still owed by the block, oldest first.
  stamp_t pending_stamps[$];
  int     errors = 0;
  int     bytes_sent = 0;

  // Idling controls shared between the stimulus and the two stream processes.
  // The percentages give the chance of a gap after each beat; a non-zero
  // tready_hold asks the receiver to hold off for that many cycles.
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int tready_hold = 0;

  // Copy of the configuration, updated at the edge that writes each register.
  logic        cfg_step20 = 1'b0;
  logic [31:0] cfg_off_sec = 32'd0;
  logic [42:0] cfg_off_frac = 43'd0;

  // Copy of the frame assembler. Position 0 means idle.
  int          asm_pos = 0;
  logic [7:0]  asm_xor = 8'h00;
  bit          asm_hdr_ok = 1'b1;
  logic [7:0]  asm_number = 8'h00;
  logic [23:0] asm_coarse = 24'd0;
  logic [23:0] asm_medium = 24'd0;
  logic [23:0] asm_fine = 24'd0;

  // Corrected arrival time of the assembled frame. The coarse and medium
  // counts form one step count which is split into whole seconds and a
  // remainder first; the remainder, fine count and offset are then summed in
  // ticks and floored into a carry of -1 up to +2 seconds.
  function automatic void frame_time(output logic [31:0] secs, output logic [42:0] frac);
    logic [49:0]     steps;
    longint unsigned whole;
    longint unsigned rem;
    longint          ticks;
    longint          carry;
    steps = {2'b00, asm_coarse, asm_medium};
    steps = steps << cfg_step20;
    whole = steps / STEPS_PER_SECOND;
    rem = steps % STEPS_PER_SECOND;
    ticks = longint'(rem * 65536) + longint'(asm_fine) - FINE_BIAS + longint'(cfg_off_frac);
    if (ticks >= 0) begin
      carry = ticks / SECOND_TICKS;
    end else begin
      carry = -((-ticks + SECOND_TICKS - 1) / SECOND_TICKS);
    end
    ticks = ticks - carry * SECOND_TICKS;
    secs = whole[31:0] + cfg_off_sec + carry[31:0];
    frac = ticks[42:0];
  endfunction

  // Advances the assembler copy by one accepted byte. Returns 1 with the
  // timestamp in stamp when the byte completes a frame. A byte without the
  // start flag while idle is dropped.
  function automatic bit assemble_byte(input logic [7:0] b, input logic start,
                                       output stamp_t stamp);
    int p;
    stamp = '0;
    if (start) begin
      asm_xor = 8'h00;
      asm_hdr_ok = 1'b1;
      p = 0;
    end else begin
      if (asm_pos == 0) return 1'b0;
      p = asm_pos;
    end
    if (p < FRAME_BYTES - 1) begin
      asm_xor = asm_xor ^ b;
      if (p == 0) asm_hdr_ok = (b == HDR_BYTE0);
      else if (p == 1) asm_hdr_ok = asm_hdr_ok && (b == HDR_BYTE1);
      else if (p == 2) asm_number = b;
      else if (p <= 5) asm_coarse[8*(p-3) +: 8] = b;
      else if (p <= 8) asm_medium[8*(p-6) +: 8] = b;
      else asm_fine[8*(p-9) +: 8] = b;
      asm_pos = p + 1;
      return 1'b0;
    end
    // Checksum byte: the checksum error wins over a bad header, and either
    // error leaves the time fields at zero.
    asm_pos = 0;
    stamp.number = asm_number;
    if (asm_xor != b) begin
      stamp.status = ST_CSUM;
    end else if (!asm_hdr_ok) begin
      stamp.status = ST_HDR;
    end else begin
      stamp.status = ST_OK;
      frame_time(stamp.secs, stamp.frac);
    end
    return 1'b1;
  endfunction

  // Counts biased towards the corners: zero, all ones, the fine zero point and one above it.
  function automatic logic [23:0] pick_count();
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h3FFFFF;
      3: return 24'h400000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Offers one byte beat and waits for it to be taken. Valid stays high into
  // the next beat unless a gap is drawn. When the byte completes a frame the
  // predicted timestamp is queued, or the typed one where the caller gives it.
  task automatic send_byte(input logic [7:0] b, input logic start, input bit typed,
                           input stamp_t want);
    stamp_t stamp;
    int     gap;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= start;
    do @(posedge clk); while (!in_tready);
    if (assemble_byte(b, start, stamp)) pending_stamps.push_back(typed ? want : stamp);
    if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(50, 20) : $urandom_range(3, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends one full frame, optionally preceded by stray or abandoned bytes.
  // The checksum byte is the XOR of the first twelve, spoilt on request.
  task automatic send_frame(input logic [7:0] hdr0, input logic [7:0] hdr1,
                            input logic [7:0] number, input logic [23:0] coarse,
                            input logic [23:0] middle, input logic [23:0] fine,
                            input bit csum_bad, input lead_t lead, input bit typed,
                            input stamp_t want);
    logic [7:0] fb [FRAME_BYTES];
    logic [7:0] sum;
    int         n;
    fb[0] = hdr0;
    fb[1] = hdr1;
    fb[2] = number;
    for (int i = 0; i < 3; i++) begin
      fb[3+i] = coarse[8*i +: 8];
      fb[6+i] = middle[8*i +: 8];
      fb[9+i] = fine[8*i +: 8];
    end
    sum = 8'h00;
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum = sum ^ fb[i];
    fb[FRAME_BYTES-1] = csum_bad ? (sum ^ 8'($urandom_range(255, 1))) : sum;

    if (lead == LEAD_STRAY) begin
      // Frames always end complete here, so the assembler is idle and these
      // bytes must vanish without a trace.
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
    end else if (lead == LEAD_PARTIAL) begin
      n = $urandom_range(FRAME_BYTES - 1, 1);
      send_byte(($urandom_range(1) != 0) ? HDR_BYTE0 : 8'($urandom), 1'b1, 1'b0, '0);
      for (int i = 1; i < n; i++) send_byte(8'($urandom), 1'b0, 1'b0, '0);
      bytes_sent += n;
    end
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(fb[i], i == 0, typed, want);
    bytes_sent += FRAME_BYTES;
  endtask

  // Register write: setup cycle, then access cycle until pready, then an
  // idle cycle so that back-to-back writes never reassign psel in one step.
  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_STEP:     cfg_step20 = value[0];
      REG_OFF_SEC:  cfg_off_sec = value[31:0];
      REG_OFF_FRAC: cfg_off_frac = value[42:0];
      default: ;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Drops valid, waits for every owed timestamp, then lets the time pipeline
  // settle so the block is truly idle before registers change.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Receiver. Mostly ready, with random short and occasional long stalls.
  // A hold-off request from the stimulus is counted down here, independently
  // of the sender, so that the block backs up and stalls its byte input.
  initial begin : result_sink
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (tready_hold > 0) begin
        out_tready <= 1'b0;
        repeat (tready_hold) @(posedge clk);
        tready_hold = 0;
        out_tready <= 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
        gap = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker. Every accepted beat is matched field by field against the
  // oldest owed timestamp; a beat with nothing owed is itself a failure.
  always @(posedge clk) begin : result_check
    stamp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_stamps.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got data %0h status %0d",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_stamps.pop_front();
        check_field("event_number", 64'(want.number), 64'(out_tdata[7:0]));
        check_field("whole_seconds", 64'(want.secs), 64'(out_tdata[39:8]));
        check_field("fraction_ticks", 64'(want.frac), 64'(out_tdata[82:40]));
        check_field("status", 64'(want.status), 64'(out_tuser));
      end
    end
  end

  // Main stimulus: a directed table with the reset configuration, then eight
  // phases (four pinned, four random), each with its own settings and idling.
  initial begin : stimulus
    frame_row_t rows [12];
    logic [7:0] hdr0;
    logic [7:0] hdr1;
    lead_t      lead;
    logic       step;
    logic [31:0] secs;
    logic [42:0] frac;
    int         pick;
    int         goal;

    // With all registers at zero the error frames and the frames whose time
    // sits at or near the fine zero point can be read off directly.
    rows[0]  = '{HDR_BYTE0, HDR_BYTE1, 8'h00, 24'h000000, 24'h000000, 24'h3FFFFF,
                 1'b0, LEAD_NONE, 1'b1, '{8'h00, 32'h00000000, 43'd0, ST_OK}};
    rows[1]  = '{HDR_BYTE0, HDR_BYTE1, 8'hFF, 24'h000000, 24'h000000, 24'h000000,
                 1'b0, LEAD_NONE, 1'b1, '{8'hFF, 32'hFFFFFFFF, 43'd6553595805697, ST_OK}};
    rows[2]  = '{HDR_BYTE0, HDR_BYTE1, 8'h5A, 24'h000000, 24'h000000, 24'h400000,
                 1'b0, LEAD_NONE, 1'b1, '{8'h5A, 32'h00000000, 43'd1, ST_OK}};
    rows[3]  = '{HDR_BYTE0, HDR_BYTE1, 8'h11, 24'h123456, 24'h654321, 24'hABCDEF,
                 1'b1, LEAD_NONE, 1'b1, '{8'h11, 32'h00000000, 43'd0, ST_CSUM}};
    rows[4]  = '{8'h00, HDR_BYTE1, 8'h22, 24'h000001, 24'h000002, 24'h000003,
                 1'b0, LEAD_NONE, 1'b1, '{8'h22, 32'h00000000, 43'd0, ST_HDR}};
    rows[5]  = '{HDR_BYTE0, 8'h0A, 8'h33, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                 1'b0, LEAD_NONE, 1'b1, '{8'h33, 32'h00000000, 43'd0, ST_HDR}};
    // Both errors at once: the checksum error takes precedence.
    rows[6]  = '{8'hFF, 8'hF4, 8'h44, 24'h000000, 24'h000000, 24'h000000,
                 1'b1, LEAD_NONE, 1'b1, '{8'h44, 32'h00000000, 43'd0, ST_CSUM}};
    rows[7]  = '{HDR_BYTE0, HDR_BYTE1, 8'h80, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                 1'b0, LEAD_NONE, 1'b0, '0};
    rows[8]  = '{HDR_BYTE0, HDR_BYTE1, 8'h01, 24'h123456, 24'h789ABC, 24'h0F0F0F,
                 1'b0, LEAD_STRAY, 1'b0, '0};
    rows[9]  = '{HDR_BYTE0, HDR_BYTE1, 8'hA5, 24'h00ABCD, 24'hFEDCBA, 24'h3FFFFE,
                 1'b0, LEAD_PARTIAL, 1'b0, '0};
    rows[10] = '{HDR_BYTE0, HDR_BYTE1, 8'h7F, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                 1'b0, LEAD_NONE, 1'b0, '0};
    rows[11] = '{HDR_BYTE0, HDR_BYTE1, 8'hC3, 24'hFFFFFF, 24'h000000, 24'h000000,
                 1'b0, LEAD_PARTIAL, 1'b0, '0};

    while (!rst_n) @(posedge clk);

    foreach (rows[i]) begin
      send_frame(rows[i].hdr0, rows[i].hdr1, rows[i].number, rows[i].coarse,
                 rows[i].middle, rows[i].fine, rows[i].csum_bad, rows[i].lead,
                 rows[i].typed, rows[i].want);
    end
    drain_results();

    for (int phase = 0; phase < 8; phase++) begin
      // The first four phases pin the registers at their extremes, including a
      // fraction offset beyond one second and offsets that wrap the seconds.
      case (phase)
        0: begin step = 1'b1; secs = 32'h00000000; frac = 43'd0; end
        1: begin step = 1'b0; secs = 32'h7FFFFFFF; frac = 43'd6553599999999; end
        2: begin step = 1'b1; secs = 32'h80000000; frac = 43'd0; end
        3: begin step = 1'b0; secs = 32'hFFFFFFFF; frac = 43'h7FFFFFFFFFF; end
        default: begin
          step = 1'($urandom);
          secs = $urandom;
          frac = 43'({$urandom, $urandom} % 64'd6553600000000);
        end
      endcase
      cfg_write(REG_STEP, 64'(step));
      cfg_write(REG_OFF_SEC, 64'(secs));
      cfg_write(REG_OFF_FRAC, 64'(frac));

      // Phase 0 runs flat out on both sides; the rest draw their own idling.
      tx_gap_pct = (phase == 0) ? 0 : $urandom_range(35, 5);
      rx_stall_pct = (phase == 0) ? 0 : $urandom_range(40, 5);
      // In phase 1 the receiver holds off while the sender keeps offering,
      // which fills the frame queue and has to stall the byte input.
      if (phase == 1) tready_hold = HOLD_CYCLES;

      goal = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < goal) begin
        pick = $urandom_range(99);
        lead = (pick < 8) ? LEAD_PARTIAL : (pick < 14) ? LEAD_STRAY : LEAD_NONE;
        hdr0 = HDR_BYTE0;
        hdr1 = HDR_BYTE1;
        pick = $urandom_range(99);
        if (pick < 5) hdr0 = 8'($urandom);
        else if (pick < 10) hdr1 = 8'($urandom);
        send_frame(hdr0, hdr1, 8'($urandom), pick_count(), pick_count(), pick_count(),
                   $urandom_range(99) < 7, lead, 1'b0, '0);
        // In phase 2 the sender now and then waits until every result is out.
        if (phase == 2 && $urandom_range(3) == 0) begin
          in_tvalid <= 1'b0;
          while (pending_stamps.size() != 0) @(posedge clk);
        end
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("PASS timestamp_frame_decoder_top");
    end else begin
      $display("FAIL timestamp_frame_decoder_top");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #8000000;
    $display("FAIL timestamp_frame_decoder_top");
    $finish;
  end

endmodule
